>>> rtl/file_magic_signature_matcher_macros.svh
// assertion macros for the file magic signature matcher
`ifndef FILE_MAGIC_SIGNATURE_MATCHER_MACROS_SVH
`define FILE_MAGIC_SIGNATURE_MATCHER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define FMSM_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("fmsm assertion failed");

// next-cycle implication
`define FMSM_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("fmsm assertion failed");

`else

`define FMSM_ASSERT_IMP(lbl, clk_i, rst_n_i, ante, cons)
`define FMSM_ASSERT_NXT(lbl, clk_i, rst_n_i, ante, cons)

`endif

`endif

>>> rtl/fmsm_pkg.sv
`timescale 1ns / 1ps

package fmsm_pkg;

	localparam int NUM_SIG   = 31;
	localparam int SIG_BYTES = 16;
	localparam int IDX_W     = 4;
	localparam int POS_W     = 5;
	localparam int TYPE_W    = 5;

	typedef logic [7:0]          byte_t;
	typedef logic [NUM_SIG-1:0]  sig_vec_t;
	typedef logic [POS_W-1:0]    pos_t;
	typedef logic [TYPE_W-1:0]   ftype_t;
	typedef logic [IDX_W-1:0]    idx_t;

	typedef struct packed {
		sig_vec_t alive;
		pos_t     pos;
	} match_state_t;

	localparam ftype_t FT_UNKNOWN = 5'd0;
	localparam ftype_t FT_ASF     = 5'd1;
	localparam ftype_t FT_JPG     = 5'd2;
	localparam ftype_t FT_PNG     = 5'd3;
	localparam ftype_t FT_WAV     = 5'd4;
	localparam ftype_t FT_DEB     = 5'd5;
	localparam ftype_t FT_BLEND   = 5'd6;
	localparam ftype_t FT_GIF     = 5'd7;
	localparam ftype_t FT_7Z      = 5'd8;
	localparam ftype_t FT_PDF     = 5'd9;
	localparam ftype_t FT_ZIP     = 5'd10;
	localparam ftype_t FT_OGG     = 5'd11;
	localparam ftype_t FT_FLAC    = 5'd12;
	localparam ftype_t FT_MKV     = 5'd13;
	localparam ftype_t FT_WASM    = 5'd14;
	localparam ftype_t FT_MPEG    = 5'd15;
	localparam ftype_t FT_NES     = 5'd16;
	localparam ftype_t FT_MP3     = 5'd17;
	localparam ftype_t FT_GZ      = 5'd18;
	localparam ftype_t FT_BMP     = 5'd19;

	localparam pos_t   POS_MAX    = POS_W'(SIG_BYTES);
	localparam sig_vec_t ALL_ALIVE = '1;

	localparam ftype_t SIG_TYPE [NUM_SIG] = '{
		FT_ASF,  FT_JPG,  FT_JPG,  FT_PNG,  FT_WAV,  FT_DEB,  FT_BLEND, FT_GIF,
		FT_GIF,  FT_7Z,   FT_PDF,  FT_JPG,  FT_JPG,  FT_JPG,  FT_ZIP,   FT_ZIP,
		FT_ZIP,  FT_OGG,  FT_FLAC, FT_MKV,  FT_WASM, FT_MPEG, FT_MPEG,  FT_NES,
		FT_MP3,  FT_NES,  FT_GZ,   FT_MP3,  FT_MP3,  FT_MP3,  FT_BMP
	};

	localparam pos_t SIG_LEN [NUM_SIG] = '{
		5'd16, 5'd12, 5'd12, 5'd8, 5'd12, 5'd8, 5'd7, 5'd6,
		5'd6,  5'd6,  5'd5,  5'd4, 5'd4,  5'd4, 5'd4, 5'd4,
		5'd4,  5'd4,  5'd4,  5'd4, 5'd4,  5'd4, 5'd4, 5'd4,
		5'd3,  5'd3,  5'd2,  5'd2, 5'd2,  5'd2, 5'd2
	};

	// bit n set: byte n is not compared
	localparam logic [SIG_BYTES-1:0] SIG_WILD [NUM_SIG] = '{
		16'h0000, 16'h0000, 16'h0030, 16'h0000, 16'h00F0, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
		16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000
	};

	// byte 0 in the top bits
	localparam logic [SIG_BYTES*8-1:0] SIG_PAT [NUM_SIG] = '{
		128'h3026B275_8E66CF11_A6D900AA_0062CE6C,
		128'hFFD8FFE0_00104A46_49460001_00000000,
		128'hFFD8FFE1_00004578_69660000_00000000,
		128'h89504E47_0D0A1A0A_00000000_00000000,
		128'h52494646_00000000_57415645_00000000,
		128'h213C6172_63683E0A_00000000_00000000,
		128'h424C454E_44455200_00000000_00000000,
		128'h47494638_37610000_00000000_00000000,
		128'h47494638_39610000_00000000_00000000,
		128'h377ABCAF_271C0000_00000000_00000000,
		128'h25504446_2D000000_00000000_00000000,
		128'hFFD8FFDB_00000000_00000000_00000000,
		128'hFFD8FFEE_00000000_00000000_00000000,
		128'hFFD8FFE0_00000000_00000000_00000000,
		128'h504B0304_00000000_00000000_00000000,
		128'h504B0506_00000000_00000000_00000000,
		128'h504B0708_00000000_00000000_00000000,
		128'h4F676753_00000000_00000000_00000000,
		128'h664C6143_00000000_00000000_00000000,
		128'h1A45DFA3_00000000_00000000_00000000,
		128'h0061736D_00000000_00000000_00000000,
		128'h000001BA_00000000_00000000_00000000,
		128'h000001B3_00000000_00000000_00000000,
		128'h4E45531A_00000000_00000000_00000000,
		128'h49443300_00000000_00000000_00000000,
		128'h4E455300_00000000_00000000_00000000,
		128'h1F8B0000_00000000_00000000_00000000,
		128'hFFFB0000_00000000_00000000_00000000,
		128'hFFF30000_00000000_00000000_00000000,
		128'hFFF20000_00000000_00000000_00000000,
		128'h424D0000_00000000_00000000_00000000
	};

endpackage

>>> rtl/fmsm_compare.sv
`timescale 1ns / 1ps

module fmsm_compare
	import fmsm_pkg::*;
(
	input  match_state_t cur,
	input  byte_t        data_byte,
	output match_state_t nxt
);

	idx_t     idx;
	sig_vec_t kill;
	logic     in_window;

	assign in_window = (cur.pos < POS_MAX);
	assign idx       = cur.pos[IDX_W-1:0];

	always_comb begin
		logic [SIG_BYTES*8-1:0] shifted;
		for (int s = 0; s < NUM_SIG; s++) begin
			shifted = SIG_PAT[s] << {idx, 3'b000};
			kill[s] = (cur.pos < SIG_LEN[s]) && !SIG_WILD[s][idx] &&
				(shifted[SIG_BYTES*8-1 -: 8] != data_byte);
		end
	end

	always_comb begin
		nxt = cur;
		if (in_window) begin
			nxt.alive = cur.alive & ~kill;
			nxt.pos   = cur.pos + POS_W'(1);
		end
	end

endmodule

>>> rtl/fmsm_select.sv
`timescale 1ns / 1ps

module fmsm_select
	import fmsm_pkg::*;
(
	input  match_state_t st,
	output ftype_t       file_type
);

	// walk down so the lowest matching entry wins
	always_comb begin
		file_type = FT_UNKNOWN;
		for (int s = NUM_SIG - 1; s >= 0; s--) begin
			if (st.alive[s] && (st.pos >= SIG_LEN[s])) begin
				file_type = SIG_TYPE[s];
			end
		end
	end

endmodule

>>> rtl/file_magic_signature_matcher.sv
// out_valid rises as the last byte moves from the input register to the output register
// throughput: one byte per cycle while in_stall is low, one result per query
// an input register feeds the table compare, the result sits in an output register
// arst_n clears the pipeline valids, the byte position and sets all signatures alive
`timescale 1ns / 1ps
`include "file_magic_signature_matcher_macros.svh"

module file_magic_signature_matcher
	import fmsm_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  byte_t  data_byte,
	input  logic   last_byte,
	input  logic   in_valid,
	output logic   in_stall,
	output ftype_t file_type,
	output logic   out_valid,
	input  logic   out_stall
);

	logic         valid_s1;
	byte_t        data_s1;
	logic         last_s1;
	logic         adv;
	logic         accept_in;
	match_state_t state_q;
	match_state_t state_nxt;
	ftype_t       type_nxt;
	ftype_t       file_type_q;
	logic         out_valid_q;

	assign adv       = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign accept_in = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	fmsm_compare u_compare (
		.cur       (state_q),
		.data_byte (data_s1),
		.nxt       (state_nxt)
	);

	fmsm_select u_select (
		.st        (state_nxt),
		.file_type (type_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.alive <= ALL_ALIVE;
			state_q.pos   <= '0;
		end else if (adv) begin
			if (last_s1) begin
				state_q.alive <= ALL_ALIVE;
				state_q.pos   <= '0;
			end else begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			file_type_q <= type_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign file_type = file_type_q;

	`FMSM_ASSERT_IMP(a_pos_range, clk, arst_n, 1'b1, state_q.pos <= POS_MAX)
	`FMSM_ASSERT_NXT(a_clear_after_last, clk, arst_n, adv && last_s1,
		state_q.pos == '0 && state_q.alive == ALL_ALIVE)
	`FMSM_ASSERT_NXT(a_pos_step, clk, arst_n, adv && !last_s1 && state_q.pos < POS_MAX,
		state_q.pos == $past(state_q.pos) + POS_W'(1))
	`FMSM_ASSERT_IMP(a_type_range, clk, arst_n, out_valid_q, file_type_q <= FT_BMP)

endmodule
